@@ design/imufp_pkg.sv @@
// Shared types and constants for the inertial sensor frame parser.
`timescale 1ns / 1ps

package imufp_pkg;

	// Frame framing constants
	localparam logic [7:0]  PREAMBLE    = 8'hFA;
	localparam logic [7:0]  MAX_PAYLOAD = 8'd255;
	localparam logic [7:0]  DEVICE_LEN  = 8'd4;
	localparam logic [15:0] ACCEL_LEN   = 16'd12;

	// Configuration register indexes
	localparam logic [1:0] CFG_BUS_ID        = 2'd0;
	localparam logic [1:0] CFG_DEVICE_ID_MSG = 2'd1;
	localparam logic [1:0] CFG_DATA_MSG      = 2'd2;
	localparam logic [1:0] CFG_ACCEL_DATA_ID = 2'd3;

	// Frame status codes
	localparam logic [1:0] ST_DEVICE   = 2'd0;
	localparam logic [1:0] ST_ACCEL    = 2'd1;
	localparam logic [1:0] ST_OTHER    = 2'd2;
	localparam logic [1:0] ST_CSUM_ERR = 2'd3;

	// Sub-packet walker position meaning "inside a body"
	localparam logic [2:0] SUB_BODY = 3'd4;

	typedef struct packed {
		logic [7:0]  bus_id;
		logic [7:0]  sensor_id_msg;
		logic [7:0]  data_msg;
		logic [15:0] accel_data_id;
	} cfg_t;

	// Control from the frame parser to the sub-packet walker
	typedef struct packed {
		logic       clear;
		logic       step;
		logic [7:0] data;
		logic [7:0] count;
		logic [7:0] length;
	} walk_in_t;

	typedef struct packed {
		logic        accel_flag;
		logic [31:0] word_x;
		logic [31:0] word_y;
		logic [31:0] word_z;
	} walk_out_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  message_id;
		logic [31:0] sensor_id;
		logic        device_valid;
		logic [31:0] accel_x_bits;
		logic [31:0] accel_y_bits;
		logic [31:0] accel_z_bits;
		logic        accel_valid;
	} result_t;

endpackage

@@ design/imu_frame_parser_accel_extract.sv @@
// Top level of the inertial sensor frame parser with accel word extraction.
`timescale 1ns / 1ps

// Takes one received byte per transfer on the slave stream and can take a byte in every
// clock cycle. Each byte is parsed in the cycle it is accepted: preamble hunt, bus id,
// message id, length, payload and checksum, with sub-packets of a data payload tracked
// as the bytes stream by. The checksum byte produces one result transfer, which lands
// in the output register toward the master stream, or in the one-entry skid stage
// while that register still holds an untaken result; all other bytes produce none.
// s_tready drops only when both hold a result that the master side has not taken.
// Configuration writes act on the next edge and are meant to happen between frames.

module imu_frame_parser_accel_extract (
	input  logic         clk,
	input  logic         arst_n,
	// Slave stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] rx_byte
	// Master stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,   // [7:0] message_id, [39:8] sensor_id,
	                                // [40] device_valid, [72:41] accel_x_bits,
	                                // [104:73] accel_y_bits, [136:105] accel_z_bits,
	                                // [137] accel_valid, rest zero
	output logic [1:0]   m_tuser,   // [1:0] frame_status
	// Configuration write port
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	imufp_pkg::cfg_t      cfg;
	imufp_pkg::walk_in_t  walk_in;
	imufp_pkg::walk_out_t walk_out;
	imufp_pkg::result_t   res;
	imufp_pkg::result_t   out_res;
	logic                 res_valid;
	logic                 in_valid;

	assign in_valid = s_tvalid && s_tready;

	imufp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	imufp_walk u_walk (
		.clk           (clk),
		.arst_n        (arst_n),
		.accel_data_id (cfg.accel_data_id),
		.walk_in       (walk_in),
		.walk_out      (walk_out)
	);

	imufp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_byte   (s_tdata),
		.walk_in   (walk_in),
		.walk_out  (walk_out),
		.res_valid (res_valid),
		.res       (res)
	);

	imufp_obuf u_obuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res_valid),
		.push_data  (res),
		.push_ready (s_tready),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (out_res)
	);

	// Pack the result onto the master stream
	assign m_tdata = {6'd0, out_res.accel_valid, out_res.accel_z_bits, out_res.accel_y_bits,
		out_res.accel_x_bits, out_res.device_valid, out_res.sensor_id, out_res.message_id};
	assign m_tuser = out_res.status;

endmodule

@@ design/imufp_cfg.sv @@
// Configuration register file of the frame parser.
`timescale 1ns / 1ps

module imufp_cfg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	output imufp_pkg::cfg_t      cfg
);

	imufp_pkg::cfg_t cfg_q;

	// Register writes, decoded by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bus_id        <= 8'd255;
			cfg_q.sensor_id_msg <= 8'd1;
			cfg_q.data_msg      <= 8'd54;
			cfg_q.accel_data_id <= 16'h4030;
		end else if (cfg_we) begin
			unique case (cfg_index)
				imufp_pkg::CFG_BUS_ID:        cfg_q.bus_id        <= cfg_data[7:0];
				imufp_pkg::CFG_DEVICE_ID_MSG: cfg_q.sensor_id_msg <= cfg_data[7:0];
				imufp_pkg::CFG_DATA_MSG:      cfg_q.data_msg      <= cfg_data[7:0];
				imufp_pkg::CFG_ACCEL_DATA_ID: cfg_q.accel_data_id <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ design/imufp_walk.sv @@
// Sub-packet walker: tracks sub-packet headers in a data payload and collects accel words.
`timescale 1ns / 1ps

module imufp_walk (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [15:0]           accel_data_id,
	input  imufp_pkg::walk_in_t   walk_in,
	output imufp_pkg::walk_out_t  walk_out
);

	logic [2:0]  pos_q;
	logic [15:0] sub_id_q;
	logic [7:0]  len_hi_q;
	logic [7:0]  rem_q;
	logic        stopped_q;
	logic        is_accel_q;
	logic        accel_flag_q;
	logic [31:0] word_q [3];

	logic [15:0] flen;
	logic [16:0] fit_sum;
	logic        overrun;
	logic [3:0]  body_off;
	logic [1:0]  word_sel;
	logic [7:0]  rem_dec;

	// Header length check and body word selection
	always_comb begin
		flen     = {len_hi_q, walk_in.data};
		fit_sum  = {9'd0, walk_in.count} + {1'b0, flen};
		overrun  = fit_sum > {9'd0, walk_in.length};
		body_off = 4'd12 - rem_q[3:0];
		word_sel = body_off[3:2];
		rem_dec  = rem_q - 8'd1;
	end

	// Walker state, advanced once per payload byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= 3'd0;
			sub_id_q     <= 16'd0;
			len_hi_q     <= 8'd0;
			rem_q        <= 8'd0;
			stopped_q    <= 1'b0;
			is_accel_q   <= 1'b0;
			accel_flag_q <= 1'b0;
		end else if (walk_in.clear) begin
			pos_q        <= 3'd0;
			sub_id_q     <= 16'd0;
			len_hi_q     <= 8'd0;
			rem_q        <= 8'd0;
			stopped_q    <= 1'b0;
			is_accel_q   <= 1'b0;
			accel_flag_q <= 1'b0;
		end else if (walk_in.step && !stopped_q) begin
			case (pos_q)
				3'd0: begin
					sub_id_q <= {walk_in.data, 8'd0};
					pos_q    <= 3'd1;
				end
				3'd1: begin
					sub_id_q[7:0] <= walk_in.data;
					pos_q         <= 3'd2;
				end
				3'd2: begin
					len_hi_q <= walk_in.data;
					pos_q    <= 3'd3;
				end
				3'd3: begin
					if (overrun) begin
						stopped_q <= 1'b1;
						rem_q     <= 8'd0;
					end else begin
						rem_q      <= flen[7:0];
						is_accel_q <= (sub_id_q == accel_data_id) &&
							(flen == imufp_pkg::ACCEL_LEN);
						if ((sub_id_q == accel_data_id) && (flen == imufp_pkg::ACCEL_LEN)) begin
							accel_flag_q <= 1'b1;
						end
						pos_q <= (flen != 16'd0) ? imufp_pkg::SUB_BODY : 3'd0;
					end
				end
				default: begin
					if (rem_q != 8'd0) begin
						rem_q <= rem_dec;
					end
					if (rem_q <= 8'd1) begin
						pos_q <= 3'd0;
					end
				end
			endcase
		end
	end

	// Accel words shift in big-endian while an accel body streams
	always_ff @(posedge clk) begin
		if (walk_in.step && !walk_in.clear && !stopped_q && pos_q == imufp_pkg::SUB_BODY &&
				is_accel_q && rem_q != 8'd0 && rem_q <= 8'd12) begin
			case (word_sel)
				2'd0: word_q[0] <= {word_q[0][23:0], walk_in.data};
				2'd1: word_q[1] <= {word_q[1][23:0], walk_in.data};
				2'd2: word_q[2] <= {word_q[2][23:0], walk_in.data};
				default: ;
			endcase
		end
	end

	assign walk_out.accel_flag = accel_flag_q;
	assign walk_out.word_x     = word_q[0];
	assign walk_out.word_y     = word_q[1];
	assign walk_out.word_z     = word_q[2];

	// A body is never entered with nothing left in it
	a_body_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q == imufp_pkg::SUB_BODY |-> rem_q != 8'd0)
		else $error("walker inside a body with zero bytes remaining");

	// An accel body never holds more than its fixed length
	a_accel_len: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q == imufp_pkg::SUB_BODY && is_accel_q) |-> rem_q <= 8'd12)
		else $error("accel body longer than its fixed length");

	// A stopped walk stays stopped until the next frame clears it
	a_stop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(stopped_q && !walk_in.clear) |=> stopped_q)
		else $error("sub-packet walk resumed inside a frame");

endmodule

@@ design/imufp_parse.sv @@
// Frame parser: preamble hunt, header, payload, checksum and result latching.
`timescale 1ns / 1ps

module imufp_parse (
	input  logic                  clk,
	input  logic                  arst_n,
	input  imufp_pkg::cfg_t       cfg,
	input  logic                  in_valid,
	input  logic [7:0]            in_byte,
	output imufp_pkg::walk_in_t   walk_in,
	input  imufp_pkg::walk_out_t  walk_out,
	output logic                  res_valid,
	output imufp_pkg::result_t    res
);

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_BUS  = 3'd1,
		PH_MSG  = 3'd2,
		PH_LEN  = 3'd3,
		PH_PAY  = 3'd4,
		PH_CHK  = 3'd5
	} phase_t;

	phase_t      phase_q;
	logic [7:0]  count_q;
	logic [7:0]  length_q;
	logic [7:0]  sum_q;
	logic [7:0]  msg_id_q;
	logic [31:0] dev_word_q;
	logic [31:0] sensor_id_q;
	logic        device_seen_q;
	logic [31:0] accel_q [3];
	logic        accel_seen_q;

	logic [7:0]  sum_add;
	logic [7:0]  count_inc;
	logic [1:0]  status;

	// Byte sum, payload count and walker control
	always_comb begin
		sum_add        = sum_q + in_byte;
		count_inc      = count_q + 8'd1;
		walk_in.clear  = in_valid && (phase_q != PH_BUS) && (phase_q != PH_MSG) &&
			(phase_q != PH_LEN) && (phase_q != PH_PAY) && (phase_q != PH_CHK) &&
			(in_byte == imufp_pkg::PREAMBLE);
		walk_in.step   = in_valid && (phase_q == PH_PAY);
		walk_in.data   = in_byte;
		walk_in.count  = count_inc;
		walk_in.length = length_q;
	end

	// Frame verdict on the checksum byte
	always_comb begin
		if (sum_add != 8'd0) begin
			status = imufp_pkg::ST_CSUM_ERR;
		end else if (msg_id_q == cfg.sensor_id_msg && length_q == imufp_pkg::DEVICE_LEN) begin
			status = imufp_pkg::ST_DEVICE;
		end else if (msg_id_q == cfg.data_msg && walk_out.accel_flag) begin
			status = imufp_pkg::ST_ACCEL;
		end else begin
			status = imufp_pkg::ST_OTHER;
		end
		res_valid        = in_valid && (phase_q == PH_CHK);
		res.status       = status;
		res.message_id   = msg_id_q;
		res.sensor_id    = (status == imufp_pkg::ST_DEVICE) ? dev_word_q : sensor_id_q;
		res.device_valid = (status == imufp_pkg::ST_DEVICE) || device_seen_q;
		res.accel_x_bits = (status == imufp_pkg::ST_ACCEL) ? walk_out.word_x : accel_q[0];
		res.accel_y_bits = (status == imufp_pkg::ST_ACCEL) ? walk_out.word_y : accel_q[1];
		res.accel_z_bits = (status == imufp_pkg::ST_ACCEL) ? walk_out.word_z : accel_q[2];
		res.accel_valid  = (status == imufp_pkg::ST_ACCEL) || accel_seen_q;
	end

	// Phase machine with frame header registers and latched results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HUNT;
			count_q       <= 8'd0;
			length_q      <= 8'd0;
			sum_q         <= 8'd0;
			msg_id_q      <= 8'd0;
			sensor_id_q   <= 32'd0;
			device_seen_q <= 1'b0;
			accel_q[0]    <= 32'd0;
			accel_q[1]    <= 32'd0;
			accel_q[2]    <= 32'd0;
			accel_seen_q  <= 1'b0;
		end else if (in_valid) begin
			unique case (phase_q)
				PH_BUS: begin
					sum_q   <= in_byte;
					phase_q <= (in_byte == cfg.bus_id) ? PH_MSG : PH_HUNT;
				end
				PH_MSG: begin
					sum_q    <= sum_add;
					msg_id_q <= in_byte;
					phase_q  <= PH_LEN;
				end
				PH_LEN: begin
					sum_q    <= sum_add;
					length_q <= in_byte;
					if (in_byte > imufp_pkg::MAX_PAYLOAD) begin
						phase_q <= PH_HUNT;
					end else begin
						phase_q <= (in_byte != 8'd0) ? PH_PAY : PH_CHK;
					end
				end
				PH_PAY: begin
					sum_q   <= sum_add;
					count_q <= count_inc;
					if (count_inc >= length_q) begin
						phase_q <= PH_CHK;
					end
				end
				PH_CHK: begin
					sum_q   <= sum_add;
					phase_q <= PH_HUNT;
					if (status == imufp_pkg::ST_DEVICE) begin
						sensor_id_q   <= dev_word_q;
						device_seen_q <= 1'b1;
					end
					if (status == imufp_pkg::ST_ACCEL) begin
						accel_q[0]   <= walk_out.word_x;
						accel_q[1]   <= walk_out.word_y;
						accel_q[2]   <= walk_out.word_z;
						accel_seen_q <= 1'b1;
					end
				end
				default: begin
					if (in_byte == imufp_pkg::PREAMBLE) begin
						phase_q  <= PH_BUS;
						count_q  <= 8'd0;
						length_q <= 8'd0;
						sum_q    <= 8'd0;
					end else begin
						phase_q <= PH_HUNT;
					end
				end
			endcase
		end
	end

	// Device id word collects every payload byte big-endian
	always_ff @(posedge clk) begin
		if (in_valid && phase_q == PH_PAY) begin
			dev_word_q <= {dev_word_q[23:0], in_byte};
		end
	end

	// The checksum byte always ends the frame
	a_chk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && phase_q == PH_CHK) |=> phase_q == PH_HUNT)
		else $error("parser did not return to hunt after the checksum byte");

	// The payload count stays below the frame length while the payload streams
	a_pay_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAY |-> count_q < length_q)
		else $error("payload count reached the frame length inside the payload");

	// A result never clears a sticky valid flag
	a_seen_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(device_seen_q && accel_seen_q) |=> (device_seen_q && accel_seen_q))
		else $error("latched valid flag dropped");

endmodule

@@ design/imufp_obuf.sv @@
// Result output register with a skid stage toward the master stream.
`timescale 1ns / 1ps

module imufp_obuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  imufp_pkg::result_t  push_data,
	output logic                push_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output imufp_pkg::result_t  out_data
);

	logic               out_valid_q;
	logic               skid_valid_q;
	imufp_pkg::result_t out_q;
	imufp_pkg::result_t skid_q;
	logic               pop;

	assign pop = out_valid_q && out_ready;

	// Valid flags of the two entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload moves: skid refills the output, or a new result lands
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_q <= push_data;
			end else begin
				out_q <= push_data;
			end
		end
	end

	assign push_ready = !skid_valid_q;
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

	// The skid entry is only used behind a full output register
	a_skid_behind: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held with an empty output register");

	// No result is pushed while the skid entry is occupied
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_valid_q)
		else $error("result pushed into a full output buffer");

endmodule

@@ test/imu_frame_parser_accel_extract_test.sv @@
// Self-checking testbench for the inertial sensor frame parser with accel word extraction.
`timescale 1ns / 1ps

module imu_frame_parser_accel_extract_test;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_BYTES   = 270;
	localparam int WHOLE          = 256;

	typedef enum logic [2:0] {P_HUNT, P_BUS, P_MSG, P_LEN, P_PAY, P_CHK} phase_t;
	typedef logic [7:0] byte_q_t[$];

	logic         clk       = 1'b0;
	logic         arst_n    = 1'b0;
	logic         s_tvalid  = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata   = 8'h00;
	logic         m_tvalid;
	logic         m_tready  = 1'b0;
	logic [143:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         cfg_we    = 1'b0;
	logic [1:0]   cfg_index = 2'd0;
	logic [15:0]  cfg_data  = 16'h0000;

	// Shadow of the configuration registers, starting at their reset values
	imufp_pkg::cfg_t cfg = {8'hFF, 8'h01, 8'h36, 16'h4030};

	// Parser state as the predictor tracks it
	phase_t      ph          = P_HUNT;
	logic [7:0]  pay_cnt     = 8'h00;
	logic [7:0]  pay_len     = 8'h00;
	logic [7:0]  csum        = 8'h00;
	logic [7:0]  frame_msg   = 8'h00;
	logic [2:0]  hdr_pos     = 3'd0;
	logic [15:0] sub_ident   = 16'h0000;
	logic [15:0] sub_left    = 16'h0000;
	logic        walk_off    = 1'b0;
	logic        sub_accel   = 1'b0;
	logic        accel_found = 1'b0;
	logic [31:0] accel_word [3] = '{default: 32'h0};
	logic [31:0] id_word     = 32'h0;
	logic [31:0] accel_latched [3] = '{default: 32'h0};
	logic [31:0] dev_latched = 32'h0;
	logic        dev_seen    = 1'b0;
	logic        acc_seen    = 1'b0;

	imufp_pkg::result_t frame_results_q[$];

	bit steady = 1'b0;
	int errors = 0;
	int bytes_sent = 0;
	int settings_used = 0;
	int idle_count = 0;
	int status_count [4] = '{default: 0};

	imu_frame_parser_accel_extract dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Sub-packet walker: tracks headers and collects the accel words as they pass.
	function automatic void walk_sub_packet(input logic [7:0] b);
		logic [15:0] flen;
		int          off;
		if (walk_off)
			return;
		if (hdr_pos < imufp_pkg::SUB_BODY) begin
			case (hdr_pos)
				3'd0: sub_ident = {b, 8'h00};
				3'd1: sub_ident = {sub_ident[15:8], b};
				3'd2: sub_left = {b, 8'h00};
				default: begin
					flen = {sub_left[15:8], b};
					if (int'(pay_cnt) + int'(flen) > int'(pay_len)) begin
						walk_off = 1'b1;
						sub_left = 16'h0000;
						return;
					end
					sub_left = flen;
					sub_accel = (sub_ident == cfg.accel_data_id) &&
						(flen == imufp_pkg::ACCEL_LEN);
					if (sub_accel)
						accel_found = 1'b1;
					hdr_pos = (flen != 16'h0000) ? imufp_pkg::SUB_BODY : 3'd0;
					return;
				end
			endcase
			hdr_pos = hdr_pos + 3'd1;
			return;
		end
		if (sub_accel && sub_left <= imufp_pkg::ACCEL_LEN && sub_left != 16'h0000) begin
			off = int'(imufp_pkg::ACCEL_LEN) - int'(sub_left);
			if (off / 4 < 3)
				accel_word[off / 4] = {accel_word[off / 4][23:0], b};
		end
		if (sub_left != 16'h0000)
			sub_left = sub_left - 16'h0001;
		if (sub_left == 16'h0000)
			hdr_pos = 3'd0;
	endfunction

	// Frame parser predictor: one byte in, a result queued on each checksum byte.
	function automatic void parse_byte(input logic [7:0] b);
		imufp_pkg::result_t r;
		case (ph)
			P_BUS: begin
				csum = b;
				ph = (b == cfg.bus_id) ? P_MSG : P_HUNT;
			end
			P_MSG: begin
				csum = csum + b;
				frame_msg = b;
				ph = P_LEN;
			end
			P_LEN: begin
				csum = csum + b;
				pay_len = b;
				if (b > imufp_pkg::MAX_PAYLOAD)
					ph = P_HUNT;
				else if (b != 8'h00)
					ph = P_PAY;
				else
					ph = P_CHK;
			end
			P_PAY: begin
				csum = csum + b;
				id_word = {id_word[23:0], b};
				pay_cnt = pay_cnt + 8'h01;
				walk_sub_packet(b);
				if (pay_cnt >= pay_len)
					ph = P_CHK;
			end
			P_CHK: begin
				csum = csum + b;
				ph = P_HUNT;
				if (csum != 8'h00) begin
					r.status = imufp_pkg::ST_CSUM_ERR;
				end else if (frame_msg == cfg.sensor_id_msg &&
						pay_len == imufp_pkg::DEVICE_LEN) begin
					dev_latched = id_word;
					dev_seen = 1'b1;
					r.status = imufp_pkg::ST_DEVICE;
				end else if (frame_msg == cfg.data_msg && accel_found) begin
					for (int i = 0; i < 3; i++)
						accel_latched[i] = accel_word[i];
					acc_seen = 1'b1;
					r.status = imufp_pkg::ST_ACCEL;
				end else begin
					r.status = imufp_pkg::ST_OTHER;
				end
				r.message_id   = frame_msg;
				r.sensor_id    = dev_latched;
				r.device_valid = dev_seen;
				r.accel_x_bits = accel_latched[0];
				r.accel_y_bits = accel_latched[1];
				r.accel_z_bits = accel_latched[2];
				r.accel_valid  = acc_seen;
				frame_results_q.push_back(r);
			end
			default: begin
				if (b == imufp_pkg::PREAMBLE) begin
					ph = P_BUS;
					pay_cnt = 8'h00;
					pay_len = 8'h00;
					csum = 8'h00;
					hdr_pos = 3'd0;
					sub_ident = 16'h0000;
					sub_left = 16'h0000;
					walk_off = 1'b0;
					sub_accel = 1'b0;
					accel_found = 1'b0;
					for (int i = 0; i < 3; i++)
						accel_word[i] = 32'h0;
					id_word = 32'h0;
				end else begin
					ph = P_HUNT;
				end
			end
		endcase
	endfunction

	// Send one byte, with random gaps, and predict it once the transfer is taken.
	task automatic send_byte(input logic [7:0] b);
		while (!steady && $urandom_range(0, 99) < 12) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		parse_byte(b);
		bytes_sent++;
	endtask

	// Send a frame; keep limits how many body bytes go out (a short count drops the checksum).
	task automatic send_packet(input logic [7:0] bus, input logic [7:0] msg, ref byte_q_t body,
	                           input logic [7:0] flip, input int keep);
		logic [7:0] sum;
		sum = bus + msg + 8'(body.size());
		foreach (body[i])
			sum = sum + body[i];
		send_byte(imufp_pkg::PREAMBLE);
		send_byte(bus);
		send_byte(msg);
		send_byte(8'(body.size()));
		for (int i = 0; i < body.size() && i < keep; i++)
			send_byte(body[i]);
		if (keep >= body.size())
			send_byte((8'h00 - sum) ^ flip);
	endtask

	function automatic void add_word(ref byte_q_t q, input logic [31:0] w);
		for (int i = 3; i >= 0; i--)
			q.push_back(w[8 * i +: 8]);
	endfunction

	function automatic void add_sub_packet(ref byte_q_t q, input logic [15:0] ident,
	                                       input logic [15:0] flen, input int data_bytes);
		q.push_back(ident[15:8]);
		q.push_back(ident[7:0]);
		q.push_back(flen[15:8]);
		q.push_back(flen[7:0]);
		repeat (data_bytes)
			q.push_back(8'($urandom));
	endfunction

	function automatic void add_accel_words(ref byte_q_t q, input logic [31:0] x,
	                                        input logic [31:0] y, input logic [31:0] z);
		add_sub_packet(q, cfg.accel_data_id, imufp_pkg::ACCEL_LEN, 0);
		add_word(q, x);
		add_word(q, y);
		add_word(q, z);
	endfunction

	// Mostly short payloads, now and then the longest one.
	function automatic int pick_len();
		return ($urandom_range(0, 49) == 0) ? 255 : $urandom_range(0, 48);
	endfunction

	// Build a data payload from a random mix of sub-packets.
	function automatic void fill_data_payload(ref byte_q_t q, input int max_len);
		int kind;
		int n;
		logic [15:0] ident;
		logic [15:0] flen;
		while (q.size() + 4 <= max_len) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				if (q.size() + 16 > max_len)
					break;
				add_sub_packet(q, cfg.accel_data_id, imufp_pkg::ACCEL_LEN, 12);
			end else if (kind < 65) begin
				n = $urandom_range(0, 6);
				if (q.size() + 4 + n > max_len)
					break;
				add_sub_packet(q, 16'($urandom), 16'(n), n);
			end else if (kind < 78) begin
				// Accel id with any length but the accel one
				n = $urandom_range(0, 16);
				if (n == int'(imufp_pkg::ACCEL_LEN))
					n = n + 1;
				if (q.size() + 4 + n > max_len)
					break;
				add_sub_packet(q, cfg.accel_data_id, 16'(n), n);
			end else if (kind < 88) begin
				// Declared length runs past the end of the payload
				n = $urandom_range(0, 6);
				if (q.size() + 4 + n > max_len)
					n = max_len - q.size() - 4;
				ident = $urandom_range(0, 1) ? cfg.accel_data_id : 16'($urandom);
				flen = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(256, 65535))
				                                   : 16'(n + $urandom_range(1, 4));
				add_sub_packet(q, ident, flen, n);
				return;
			end else begin
				break;
			end
		end
		// Leave an incomplete header behind now and then
		n = $urandom_range(0, 3);
		while (n > 0 && q.size() < max_len) begin
			q.push_back(8'($urandom));
			n--;
		end
	endfunction

	// One random frame, noise burst or cut-off frame under the current settings.
	task automatic random_frame();
		byte_q_t    body;
		logic [7:0] bus;
		logic [7:0] msg;
		logic [7:0] flip;
		int         kind;
		int         n;
		kind = $urandom_range(0, 99);
		bus  = ($urandom_range(0, 99) < 92) ? cfg.bus_id : 8'($urandom);
		flip = ($urandom_range(0, 99) < 8) ? 8'($urandom_range(1, 255)) : 8'h00;
		if (kind < 45) begin
			msg = cfg.data_msg;
			fill_data_payload(body, pick_len());
		end else if (kind < 60) begin
			msg = cfg.sensor_id_msg;
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 4;
			repeat (n)
				body.push_back(8'($urandom));
		end else if (kind < 72) begin
			msg = 8'($urandom);
			fill_data_payload(body, pick_len());
		end else if (kind < 80) begin
			msg = cfg.data_msg;
			repeat (pick_len())
				body.push_back(8'($urandom));
		end else if (kind < 90) begin
			repeat ($urandom_range(1, 6))
				send_byte(($urandom_range(0, 3) == 0) ? imufp_pkg::PREAMBLE : 8'($urandom));
			return;
		end else begin
			msg = cfg.data_msg;
			fill_data_payload(body, pick_len());
			n = (body.size() > 0) ? $urandom_range(0, body.size() - 1) : 0;
			send_packet(bus, msg, body, 8'h00, n);
			return;
		end
		send_packet(bus, msg, body, flip, WHOLE);
	endtask

	// Bring the parser back to preamble hunt and let every result drain.
	task automatic wait_quiet();
		while (ph != P_HUNT)
			send_byte(8'h00);
		s_tvalid <= 1'b0;
		while (frame_results_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all four registers, one per cycle, while the parser is idle.
	task automatic apply_config(input logic [7:0] bus, input logic [7:0] dev_msg,
	                            input logic [7:0] dat_msg, input logic [15:0] acc_id);
		logic [1:0]  regs [4];
		logic [15:0] vals [4];
		regs[0] = imufp_pkg::CFG_BUS_ID;
		regs[1] = imufp_pkg::CFG_DEVICE_ID_MSG;
		regs[2] = imufp_pkg::CFG_DATA_MSG;
		regs[3] = imufp_pkg::CFG_ACCEL_DATA_ID;
		vals[0] = {8'h00, bus};
		vals[1] = {8'h00, dev_msg};
		vals[2] = {8'h00, dat_msg};
		vals[3] = acc_id;
		cfg.bus_id = bus;
		cfg.sensor_id_msg = dev_msg;
		cfg.data_msg = dat_msg;
		cfg.accel_data_id = acc_id;
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Reset settings: empty latches first, then each latch path and a bad checksum.
	task automatic test_reset_defaults();
		byte_q_t q;
		send_packet(cfg.bus_id, 8'h10, q, 8'h00, WHOLE);
		add_word(q, 32'hFFFF_FFFF);
		send_packet(cfg.bus_id, cfg.sensor_id_msg, q, 8'h00, WHOLE);
		q.delete();
		add_accel_words(q, 32'hFFFF_FFFF, 32'h0000_0000, 32'h3F80_0000);
		send_packet(cfg.bus_id, cfg.data_msg, q, 8'h00, WHOLE);
		q.delete();
		add_word(q, 32'h1234_5678);
		send_packet(cfg.bus_id, cfg.sensor_id_msg, q, 8'h01, WHOLE);
	endtask

	// Framing and sub-packet corner cases under the reset settings.
	task automatic test_special_cases();
		byte_q_t q;
		// Wrong bus id; the mismatching preamble value is not taken as a new start
		send_byte(imufp_pkg::PREAMBLE);
		send_byte(imufp_pkg::PREAMBLE);
		send_byte(8'hFF);
		send_byte(imufp_pkg::PREAMBLE);
		send_byte(8'h00);
		// Zero length on the data message, and a device reply of the wrong length
		send_packet(cfg.bus_id, cfg.data_msg, q, 8'h00, WHOLE);
		repeat (5) q.push_back(8'h5A);
		send_packet(cfg.bus_id, cfg.sensor_id_msg, q, 8'h00, WHOLE);
		// An overrunning sub-packet stops the walk before a valid accel one
		q.delete();
		add_sub_packet(q, 16'h1111, 16'd40, 2);
		add_accel_words(q, 32'h0BAD_0001, 32'h0BAD_0002, 32'h0BAD_0003);
		send_packet(cfg.bus_id, cfg.data_msg, q, 8'h00, WHOLE);
		// Accel followed by an incomplete header
		q.delete();
		add_accel_words(q, 32'h4120_0000, 32'hC120_0000, 32'h7F80_0000);
		repeat (3) q.push_back(8'h40);
		send_packet(cfg.bus_id, cfg.data_msg, q, 8'h00, WHOLE);
		// Two accel sub-packets: the later one wins
		q.delete();
		add_accel_words(q, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333);
		add_accel_words(q, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_00FF);
		send_packet(cfg.bus_id, cfg.data_msg, q, 8'h00, WHOLE);
		// Accel id with the wrong length, then an empty sub-packet ahead of accel
		q.delete();
		add_sub_packet(q, cfg.accel_data_id, 16'd8, 8);
		send_packet(cfg.bus_id, cfg.data_msg, q, 8'h00, WHOLE);
		q.delete();
		add_sub_packet(q, 16'h0001, 16'd0, 0);
		add_accel_words(q, 32'h8000_0000, 32'h0000_0001, 32'hFF80_0000);
		send_packet(cfg.bus_id, cfg.data_msg, q, 8'h00, WHOLE);
		// Longest payload with the accel sub-packet right at its end
		q.delete();
		add_sub_packet(q, 16'h2222, 16'd235, 235);
		add_accel_words(q, 32'h3F00_0000, 32'hBF00_0000, 32'h4000_0000);
		send_packet(cfg.bus_id, cfg.data_msg, q, 8'h00, WHOLE);
		// Accel on another message id, and accel with a bad checksum
		q.delete();
		add_accel_words(q, 32'hDEAD_0001, 32'hDEAD_0002, 32'hDEAD_0003);
		send_packet(cfg.bus_id, cfg.data_msg + 8'h01, q, 8'h00, WHOLE);
		send_packet(cfg.bus_id, cfg.data_msg, q, 8'h80, WHOLE);
	endtask

	// Several register settings, extremes and shared message ids among them.
	task automatic test_config_settings();
		byte_q_t    q;
		logic [7:0] shared;
		for (int s = 0; s < 5; s++) begin
			wait_quiet();
			case (s)
				0: apply_config(8'h00, 8'h00, 8'hFF, 16'h0000);
				1: apply_config(8'hFF, 8'hFF, 8'h00, 16'hFFFF);
				2: begin
					shared = 8'($urandom);
					apply_config(8'($urandom), shared, shared, 16'($urandom));
				end
				3: apply_config(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
				default: apply_config(8'hFF, 8'h01, 8'h36, 16'h4030);
			endcase
			q.delete();
			add_word(q, $urandom);
			send_packet(cfg.bus_id, cfg.sensor_id_msg, q, 8'h00, WHOLE);
			q.delete();
			add_accel_words(q, $urandom, $urandom, $urandom);
			send_packet(cfg.bus_id, cfg.data_msg, q, 8'h00, WHOLE);
			repeat (2) random_frame();
		end
	endtask

	// The sender holds off after each frame until its result has come back.
	task automatic test_pause_for_results();
		repeat (6) begin
			random_frame();
			wait_quiet();
		end
	endtask

	// Bulk random traffic, with a middle stretch where neither side idles.
	task automatic test_random_traffic();
		int start;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			steady = (bytes_sent - start > RANDOM_BYTES / 3) &&
			         (bytes_sent - start < 2 * RANDOM_BYTES / 3);
			random_frame();
		end
		steady = 1'b0;
	endtask

	function automatic void compare_field(input string name, input logic [31:0] want,
	                                      input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	// The result side stalls at random except during the steady stretch.
	always @(posedge clk)
		m_tready <= steady || ($urandom_range(0, 99) >= 12);

	// Result checking against the oldest expected result, plus the stall watchdog.
	always @(posedge clk) begin : check_results
		imufp_pkg::result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				status_count[m_tuser]++;
				if (frame_results_q.size() == 0) begin
					errors++;
					$display("%0t ns: result transfer with none expected, status %0d, message %0h",
					         $time, m_tuser, m_tdata[7:0]);
				end else begin
					want = frame_results_q.pop_front();
					compare_field("frame_status", 32'(want.status), 32'(m_tuser));
					compare_field("message_id", 32'(want.message_id), 32'(m_tdata[7:0]));
					compare_field("sensor_id", want.sensor_id, m_tdata[39:8]);
					compare_field("device_valid", 32'(want.device_valid), 32'(m_tdata[40]));
					compare_field("accel_x_bits", want.accel_x_bits, m_tdata[72:41]);
					compare_field("accel_y_bits", want.accel_y_bits, m_tdata[104:73]);
					compare_field("accel_z_bits", want.accel_z_bits, m_tdata[136:105]);
					compare_field("accel_valid", 32'(want.accel_valid), 32'(m_tdata[137]));
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_count = 0;
			end else begin
				idle_count = idle_count + 1;
				if (idle_count >= WATCHDOG_LIMIT) begin
					$display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
					         $time, WATCHDOG_LIMIT, frame_results_q.size());
					$display("RESULT: ERROR");
					$finish;
				end
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_special_cases();
		test_config_settings();
		test_pause_for_results();
		test_random_traffic();
		wait_quiet();
		repeat (12) @(posedge clk);
		$display("Sent %0d bytes under %0d register settings; frames seen: %0d device id,",
		         bytes_sent, settings_used, status_count[imufp_pkg::ST_DEVICE]);
		$display("%0d accel, %0d other good, %0d checksum errors; %0d mismatches.",
		         status_count[imufp_pkg::ST_ACCEL], status_count[imufp_pkg::ST_OTHER],
		         status_count[imufp_pkg::ST_CSUM_ERR], errors);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
